>>> rtl/trrb_pkg.sv
// Shared types and constants of the tagged response reorder buffer.
package trrb_pkg;

  // Size of the reorder window, tag counter width and payload handle width
  localparam int WINDOW       = 16;
  localparam int TAG_BITS     = 16;
  localparam int PAYLOAD_BITS = 32;

  // Widths of the tag and payload fields on the ports
  localparam int FIELD_TAG_BITS     = 16;
  localparam int FIELD_PAYLOAD_BITS = 32;

  // Slot index width and depth of the queue between front and back end
  localparam int SLOT_BITS   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // Result kinds
  typedef enum logic [2:0] {
    KIND_ASSIGNED  = 3'd0,
    KIND_RELEASED  = 3'd1,
    KIND_HELD      = 3'd2,
    KIND_REJECTED  = 3'd3,
    KIND_REQ_ERROR = 3'd4
  } kind_t;

  // Input action codes
  localparam logic ACTION_REQUEST  = 1'b0;
  localparam logic ACTION_RESPONSE = 1'b1;

  // Commands passed from front to back end
  typedef enum logic [1:0] {
    CMD_ASSIGN = 2'd0,
    CMD_ERROR  = 2'd1,
    CMD_RESP   = 2'd2
  } cmd_op_t;

  typedef struct packed {
    logic                          action;
    logic                          request_failed;
    logic                          keep_alive;
    logic [FIELD_TAG_BITS-1:0]     resp_tag;
    logic [FIELD_PAYLOAD_BITS-1:0] payload;
  } trrb_in_t;

  typedef struct packed {
    logic [2:0]                    kind;
    logic [FIELD_TAG_BITS-1:0]     out_tag;
    logic [FIELD_PAYLOAD_BITS-1:0] out_payload;
    logic                          close_after;
    logic                          last;
  } trrb_out_t;

  typedef struct packed {
    cmd_op_t                 op;
    logic [TAG_BITS-1:0]     tag;
    logic [PAYLOAD_BITS-1:0] payload;
    logic                    close;
  } trrb_cmd_t;

endpackage

>>> rtl/trrb_front.sv
// Front end: tags requests, tracks keep-alive and close flag, issues commands.
module trrb_front import trrb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  trrb_in_t  item,
  output logic      push_valid,
  input  logic      push_ready,
  output trrb_cmd_t push_cmd
);

  logic [TAG_BITS-1:0] next_recv_tag;
  logic                last_keep_alive;
  logic                close_pending;
  logic                accept;

  assign item_ready = push_ready;
  assign push_valid = item_valid;
  assign accept     = item_valid && push_ready;

  // Classify the item into a command for the back end
  always_comb begin
    push_cmd.op      = CMD_ERROR;
    push_cmd.tag     = '0;
    push_cmd.payload = '0;
    push_cmd.close   = close_pending;
    if (item.action == ACTION_REQUEST) begin
      if (!item.request_failed) begin
        push_cmd.op  = CMD_ASSIGN;
        push_cmd.tag = next_recv_tag;
      end
    end else begin
      push_cmd.op      = CMD_RESP;
      push_cmd.tag     = TAG_BITS'(item.resp_tag);
      push_cmd.payload = PAYLOAD_BITS'(item.payload);
      push_cmd.close   = close_pending || !last_keep_alive;
    end
  end

  // Advance the receive tag and the connection flags
  always_ff @(posedge clk) begin
    if (rst) begin
      next_recv_tag   <= '0;
      last_keep_alive <= 1'b0;
      close_pending   <= 1'b0;
    end else if (accept) begin
      if (item.action == ACTION_REQUEST) begin
        if (!item.request_failed) begin
          next_recv_tag   <= next_recv_tag + 1'b1;
          last_keep_alive <= item.keep_alive;
        end
      end else begin
        close_pending <= push_cmd.close;
      end
    end
  end

endmodule

>>> rtl/trrb_queue.sv
// Short command queue between the front and back end.
module trrb_queue import trrb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push_valid,
  output logic      push_ready,
  input  trrb_cmd_t push_cmd,
  output logic      pop_valid,
  input  logic      pop_ready,
  output trrb_cmd_t pop_cmd
);

  trrb_cmd_t            entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;
  logic                 do_push;
  logic                 do_pop;

  assign push_ready = (count != QCNT_BITS'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/trrb_back.sv
// Back end: reorder window, in-order release, drain sequencer and result register.
module trrb_back import trrb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      pop_valid,
  output logic      pop_ready,
  input  trrb_cmd_t pop_cmd,
  output logic      result_valid,
  input  logic      result_ready,
  output trrb_out_t result
);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  state_t                  state, state_next;
  logic [TAG_BITS-1:0]     send_tag, send_tag_next;
  logic [SLOT_BITS-1:0]    head, head_next, head_inc;
  logic [WINDOW-1:0]       slot_valid, slot_valid_next;
  logic [PAYLOAD_BITS-1:0] slot_payload [WINDOW];
  logic                    drain_close, drain_close_next;
  logic                    result_valid_next;
  trrb_out_t               result_next;
  logic                    can_load;
  logic                    result_load;
  logic [TAG_BITS-1:0]     tag_dist;
  logic                    in_window;
  logic [SLOT_BITS:0]      slot_sum;
  logic [SLOT_BITS:0]      slot_wrap;
  logic [SLOT_BITS-1:0]    hold_idx;
  logic                    pay_we;

  assign can_load  = !result_valid || result_ready;
  assign pop_ready = (state == ST_IDLE) && can_load;
  assign head_inc  = (head == SLOT_BITS'(WINDOW - 1)) ? '0 : head + 1'b1;

  // Place the response in the window relative to the send tag
  assign tag_dist  = pop_cmd.tag - send_tag;
  assign in_window = 64'(tag_dist) < 64'(WINDOW);
  assign slot_sum  = {1'b0, head} + (SLOT_BITS + 1)'(tag_dist);
  assign slot_wrap = (slot_sum >= (SLOT_BITS + 1)'(WINDOW)) ?
                     slot_sum - (SLOT_BITS + 1)'(WINDOW) : slot_sum;
  assign hold_idx  = slot_wrap[SLOT_BITS-1:0];

  // Execute commands and step the drain
  always_comb begin
    state_next       = state;
    send_tag_next    = send_tag;
    head_next        = head;
    slot_valid_next  = slot_valid;
    drain_close_next = drain_close;
    result_next      = result;
    result_load      = 1'b0;
    pay_we           = 1'b0;
    case (state)
      ST_IDLE: begin
        if (pop_valid && pop_ready) begin
          result_load             = 1'b1;
          result_next.kind        = KIND_REQ_ERROR;
          result_next.out_tag     = '0;
          result_next.out_payload = '0;
          result_next.close_after = pop_cmd.close;
          result_next.last        = 1'b1;
          case (pop_cmd.op)
            CMD_ASSIGN: begin
              result_next.kind    = KIND_ASSIGNED;
              result_next.out_tag = FIELD_TAG_BITS'(pop_cmd.tag);
            end
            CMD_RESP: begin
              result_next.out_tag = FIELD_TAG_BITS'(pop_cmd.tag);
              if (tag_dist == '0) begin
                // Release at once and drain whatever follows
                result_next.kind        = KIND_RELEASED;
                result_next.out_payload = FIELD_PAYLOAD_BITS'(pop_cmd.payload);
                result_next.last        = !slot_valid[head_inc];
                send_tag_next           = send_tag + 1'b1;
                head_next               = head_inc;
                if (slot_valid[head_inc]) begin
                  state_next       = ST_DRAIN;
                  drain_close_next = pop_cmd.close;
                end
              end else if (in_window) begin
                result_next.kind          = KIND_HELD;
                slot_valid_next[hold_idx] = 1'b1;
                pay_we                    = 1'b1;
              end else begin
                result_next.kind = KIND_REJECTED;
              end
            end
            default: begin
              result_next.kind = KIND_REQ_ERROR;
            end
          endcase
        end
      end
      ST_DRAIN: begin
        if (can_load) begin
          result_load             = 1'b1;
          result_next.kind        = KIND_RELEASED;
          result_next.out_tag     = FIELD_TAG_BITS'(send_tag);
          result_next.out_payload = FIELD_PAYLOAD_BITS'(slot_payload[head]);
          result_next.close_after = drain_close;
          result_next.last        = !slot_valid[head_inc];
          slot_valid_next[head]   = 1'b0;
          send_tag_next           = send_tag + 1'b1;
          head_next               = head_inc;
          if (!slot_valid[head_inc]) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    if (result_load) begin
      result_valid_next = 1'b1;
    end else if (result_ready) begin
      result_valid_next = 1'b0;
    end else begin
      result_valid_next = result_valid;
    end
  end

  // Hold early payloads in their slot
  always_ff @(posedge clk) begin
    if (pay_we) begin
      slot_payload[hold_idx] <= pop_cmd.payload;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (result_load) begin
      result <= result_next;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      send_tag     <= '0;
      head         <= '0;
      slot_valid   <= '0;
      drain_close  <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      send_tag     <= send_tag_next;
      head         <= head_next;
      slot_valid   <= slot_valid_next;
      drain_close  <= drain_close_next;
      result_valid <= result_valid_next;
    end
  end

endmodule

>>> rtl/tagged_response_reorder_buffer.sv
// Each item passes the command queue and the result register. Throughput: one item
// per cycle while each item gives one result and the receiver is ready; a response
// that releases n responses keeps the back end draining one window slot per cycle
// while the result register can load. The two-entry command queue lets the front end
// keep accepting during a drain. Reset clears tags, flags, slot valid bits, queue and
// result valid flag; held payloads and result data are not cleared.
module tagged_response_reorder_buffer import trrb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  trrb_in_t  item,
  output logic      result_valid,
  input  logic      result_ready,
  output trrb_out_t result
);

  logic      push_valid;
  logic      push_ready;
  trrb_cmd_t push_cmd;
  logic      pop_valid;
  logic      pop_ready;
  trrb_cmd_t pop_cmd;

  // Accept and classify items
  trrb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  // Decouple front and back end
  trrb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // Reorder and release responses
  trrb_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_cmd      (pop_cmd),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

>>> verif/trrb_checker.sv
// Checker for the reorder buffer: predicts the results of each item and compares them.
`timescale 1ns / 100ps

module trrb_checker import trrb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  input  logic      item_ready,
  input  trrb_in_t  item,
  input  logic      result_valid,
  input  logic      result_ready,
  input  trrb_out_t result,
  output int        mismatch_count,
  output int        outcomes_pending
);

  // Predicted state of the buffer
  logic [TAG_BITS-1:0]     recv_tag_ctr;
  logic [TAG_BITS-1:0]     send_tag_ctr;
  logic                    keep_open;
  logic                    close_flag;
  logic                    slot_held [WINDOW];
  logic [PAYLOAD_BITS-1:0] slot_data [WINDOW];

  // Results still awaited, oldest first
  trrb_out_t awaited_outcomes[$];

  task automatic push_outcome(input kind_t kind, input logic [TAG_BITS-1:0] tag,
                              input logic [PAYLOAD_BITS-1:0] pay, input logic fin);
    trrb_out_t o;
    o.kind        = kind;
    o.out_tag     = FIELD_TAG_BITS'(tag);
    o.out_payload = FIELD_PAYLOAD_BITS'(pay);
    o.close_after = close_flag;
    o.last        = fin;
    awaited_outcomes.push_back(o);
  endtask

  // Shift the window down by one place and move on to the next send tag
  task automatic shift_window();
    for (int i = 0; i + 1 < WINDOW; i++) begin
      slot_held[i] = slot_held[i + 1];
      slot_data[i] = slot_data[i + 1];
    end
    slot_held[WINDOW - 1] = 1'b0;
    slot_data[WINDOW - 1] = '0;
    send_tag_ctr = send_tag_ctr + 1'b1;
  endtask

  task automatic predict_outcomes(input trrb_in_t it);
    logic [TAG_BITS-1:0]     tag;
    logic [TAG_BITS-1:0]     tag_dist;
    logic [TAG_BITS-1:0]     rel_tag;
    logic [PAYLOAD_BITS-1:0] pay;
    logic [PAYLOAD_BITS-1:0] rel_pay;
    int                      n;
    tag = it.resp_tag[TAG_BITS-1:0];
    pay = it.payload[PAYLOAD_BITS-1:0];
    if (it.action == ACTION_REQUEST) begin
      if (it.request_failed) begin
        push_outcome(KIND_REQ_ERROR, '0, '0, 1'b1);
      end else begin
        push_outcome(KIND_ASSIGNED, recv_tag_ctr, '0, 1'b1);
        recv_tag_ctr = recv_tag_ctr + 1'b1;
        keep_open    = it.keep_alive;
      end
    end else begin
      // Any response after a non keep-alive request closes the connection
      if (!keep_open) close_flag = 1'b1;
      tag_dist = tag - send_tag_ctr;
      if (tag_dist == 0) begin
        // Release this one, then each held response that directly follows it in tag order
        rel_tag = tag;
        rel_pay = pay;
        n = 0;
        shift_window();
        while (slot_held[0] && n + 1 < WINDOW) begin
          push_outcome(KIND_RELEASED, rel_tag, rel_pay, 1'b0);
          n++;
          rel_tag = send_tag_ctr;
          rel_pay = slot_data[0];
          shift_window();
        end
        push_outcome(KIND_RELEASED, rel_tag, rel_pay, 1'b1);
      end else if (tag_dist < WINDOW) begin
        slot_held[tag_dist[SLOT_BITS-1:0]] = 1'b1;
        slot_data[tag_dist[SLOT_BITS-1:0]] = pay;
        push_outcome(KIND_HELD, tag, '0, 1'b1);
      end else begin
        push_outcome(KIND_REJECTED, tag, '0, 1'b1);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_val,
                             input logic [63:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected %0h, actual %0h", name, exp_val, act_val);
      mismatch_count++;
    end
  endtask

  // Watch both channels at every edge
  always @(posedge clk) begin
    trrb_out_t exp_res;
    if (rst) begin
      recv_tag_ctr = '0;
      send_tag_ctr = '0;
      keep_open    = 1'b0;
      close_flag   = 1'b0;
      for (int i = 0; i < WINDOW; i++) begin
        slot_held[i] = 1'b0;
        slot_data[i] = '0;
      end
      awaited_outcomes.delete();
      mismatch_count = 0;
    end else begin
      if (result_valid && result_ready) begin
        if (awaited_outcomes.size() == 0) begin
          $error("result with no item awaiting it: kind %0d tag %0h", result.kind,
                 result.out_tag);
          mismatch_count++;
        end else begin
          exp_res = awaited_outcomes.pop_front();
          check_field("kind", exp_res.kind, result.kind);
          check_field("out_tag", exp_res.out_tag, result.out_tag);
          check_field("out_payload", exp_res.out_payload, result.out_payload);
          check_field("close_after", exp_res.close_after, result.close_after);
          check_field("last", exp_res.last, result.last);
        end
      end
      if (item_valid && item_ready) predict_outcomes(item);
    end
    outcomes_pending = awaited_outcomes.size();
  end

endmodule

>>> verif/testbench.sv
// Top of the reorder buffer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
  import trrb_pkg::*;

  localparam int STALL_LIMIT     = 4000;
  localparam int LONG_HOLD_OFF   = 400;
  localparam int ITEMS_PER_PHASE = 40;

  logic      clk = 1'b0;
  logic      rst;
  logic      item_valid;
  logic      item_ready;
  trrb_in_t  item;
  logic      result_valid;
  logic      result_ready;
  trrb_out_t result;
  int        mismatch_count;
  int        outcomes_pending;

  // Stimulus controls
  int                  sender_idle_pct;
  int                  recv_stall_pct;
  bit                  hold_off_request;
  int                  items_sent;
  logic [TAG_BITS-1:0] tags_issued;

  tagged_response_reorder_buffer i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  trrb_checker i_checker (
    .clk              (clk),
    .rst              (rst),
    .item_valid       (item_valid),
    .item_ready       (item_ready),
    .item             (item),
    .result_valid     (result_valid),
    .result_ready     (result_ready),
    .result           (result),
    .mismatch_count   (mismatch_count),
    .outcomes_pending (outcomes_pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    result_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        result_ready <= 1'b0;
        repeat (LONG_HOLD_OFF) @(posedge clk);
      end else begin
        result_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((item_valid && item_ready) || (result_valid && result_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Offer one item after a random gap and hold it until accepted
  task automatic offer_item(input trrb_in_t it);
    int gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(negedge clk); while (!item_ready);
    @(posedge clk);
    items_sent++;
  endtask

  task automatic send_request(input logic failed, input logic ka);
    trrb_in_t it;
    it.action         = ACTION_REQUEST;
    it.request_failed = failed;
    it.keep_alive     = ka;
    it.resp_tag       = FIELD_TAG_BITS'($urandom);
    it.payload        = FIELD_PAYLOAD_BITS'($urandom);
    offer_item(it);
    if (!failed) tags_issued = tags_issued + 1'b1;
  endtask

  task automatic send_response(input logic [TAG_BITS-1:0] tag,
                               input logic [PAYLOAD_BITS-1:0] pay);
    trrb_in_t it;
    it.action         = ACTION_RESPONSE;
    it.request_failed = 1'($urandom_range(1));
    it.keep_alive     = 1'($urandom_range(1));
    it.resp_tag       = FIELD_TAG_BITS'(tag);
    it.payload        = FIELD_PAYLOAD_BITS'(pay);
    offer_item(it);
  endtask

  // Stop offering until every awaited result has come out
  task automatic drain_results();
    item_valid <= 1'b0;
    do @(negedge clk); while (outcomes_pending != 0);
    @(posedge clk);
  endtask

  // Issue k tags, then answer them in a shuffled or reversed order with some noise
  task automatic run_batch(input int k);
    logic [TAG_BITS-1:0] base;
    int                  order[];
    int                  j;
    int                  pick;
    int                  swap;
    base  = tags_issued;
    order = new[k];
    for (j = 0; j < k; j++) begin
      if ($urandom_range(9) == 0) send_request(1'b1, 1'($urandom_range(1)));
      send_request(1'b0, 1'($urandom_range(1)));
      order[j] = j;
    end
    if ($urandom_range(3) == 0) begin
      // Oldest tag last, so its arrival releases the whole batch
      for (j = 0; j < k; j++) order[j] = k - 1 - j;
    end else begin
      for (j = k - 1; j > 0; j--) begin
        pick        = $urandom_range(j);
        swap        = order[j];
        order[j]    = order[pick];
        order[pick] = swap;
      end
    end
    for (j = 0; j < k; j++) begin
      // Stale or far tag: always outside the window
      if ($urandom_range(9) == 0)
        send_response(base + TAG_BITS'($urandom_range(2**TAG_BITS - 1, 2 * WINDOW)),
                      $urandom);
      if ($urandom_range(11) == 0) send_request(1'b1, 1'($urandom_range(1)));
      send_response(base + TAG_BITS'(order[j]), $urandom);
      // Repeat a tag already answered: overwrite if still held, else stale
      if ($urandom_range(7) == 0)
        send_response(base + TAG_BITS'(order[$urandom_range(j)]), $urandom);
    end
  endtask

  task automatic run_phase(input int sidle, input int rstall, input bit long_hold);
    int start;
    sender_idle_pct  = sidle;
    recv_stall_pct   = rstall;
    hold_off_request = long_hold;
    start            = items_sent;
    while (items_sent - start < ITEMS_PER_PHASE)
      run_batch(($urandom_range(3) == 0) ? WINDOW : $urandom_range(6, 1));
    drain_results();
  endtask

  initial begin
    rst              <= 1'b1;
    item_valid       <= 1'b0;
    item             <= '0;
    sender_idle_pct  = 0;
    recv_stall_pct   = 0;
    hold_off_request = 1'b0;
    items_sent       = 0;
    tags_issued      = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: failed request, response before any request, hold, overwrite,
    // single and chained release, stale and far tags
    send_request(1'b1, 1'b1);
    send_response(16'h8000, '0);
    send_request(1'b0, 1'b1);
    send_request(1'b0, 1'b0);
    send_request(1'b0, 1'b1);
    send_request(1'b0, 1'b1);
    send_response(16'd2, 32'h1111_1111);
    send_response(16'd2, 32'hFFFF_FFFF);
    send_response(16'd3, 32'h0000_0000);
    send_response(16'd0, 32'hA5A5_5A5A);
    send_response(16'd1, 32'h0000_0001);
    send_response(16'd0, 32'h5A5A_A5A5);
    send_response(TAG_BITS'(4 + WINDOW), 32'hFFFF_FFFF);
    send_request(1'b1, 1'b0);
    drain_results();

    // Random phases with different idling
    run_phase(0, 0, 1'b1);
    run_phase(57, 0, 1'b0);
    run_phase(0, 57, 1'b0);
    run_phase(16, 16, 1'b0);

    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && outcomes_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/trrb_pkg.sv
rtl/trrb_front.sv
rtl/trrb_queue.sv
rtl/trrb_back.sv
rtl/tagged_response_reorder_buffer.sv
verif/trrb_checker.sv
verif/testbench.sv
